// ----- design/dconv_pkg.sv -----
// Shared types and fixed constants of the direct 2D convolution engine.
// Used by design/direct_conv2d_engine.sv; depends on nothing else.
`default_nettype none

package dconv_pkg;

	// Stream payload layout
	localparam int unsigned S_TDATA_W = 48;
	localparam int unsigned S_TUSER_W = 2;
	localparam int unsigned M_TDATA_W = 56;
	localparam int unsigned M_TUSER_W = 2;

	// Field widths fixed by the item format
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned LIDX_W  = 14;
	localparam int unsigned LVAL_W  = 16;
	localparam int unsigned OCH_W   = 4;
	localparam int unsigned OPOS_W  = 6;
	localparam int unsigned SUM_W   = 40;
	localparam int unsigned STAT_W  = 2;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;

	// Fixed geometry limits
	localparam int unsigned MAX_STEP = 8;
	localparam int unsigned MAX_PAD  = 4;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD_INPUT  = 2'd0,
		KIND_LOAD_WEIGHT = 2'd1,
		KIND_COMPUTE     = 2'd2
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_RANGE    = 2'd1,
		STATUS_GEOMETRY = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_CHANNELS   = 3'd0,
		REG_IN_HEIGHT     = 3'd1,
		REG_IN_WIDTH      = 3'd2,
		REG_OUT_CHANNELS  = 3'd3,
		REG_KERNEL_HEIGHT = 3'd4,
		REG_KERNEL_WIDTH  = 3'd5,
		REG_STEP_SIZE     = 3'd6,
		REG_PAD_AMOUNT    = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP0,
		ST_SETUP1,
		ST_SETUP2,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage : dconv_pkg

`default_nettype wire

// ----- design/direct_conv2d_engine.sv -----
// Top level of the direct 2D convolution engine: stores, sequencer and the shared MAC.
// Depends on design/dconv_pkg.sv for item codes, state encoding and fixed widths.
`default_nettype none

// Direct 2D convolution engine. Load items (tuser kind 0 or 1) write one Q8.8 value into the
// input store or the weight store; both stores use channel-major linear addresses, and a
// load past the end of its store is dropped. A compute item (kind 2) names an output channel,
// row and column and yields exactly one result: the Q24.16 sum of input times weight over
// every input channel and kernel tap, with stride and zero padding, saturated to 40 bits,
// together with an echo of the coordinate and a status (1 for a coordinate outside the output
// map, 2 for a register outside its range or a kernel larger than the padded input; the sum
// is zero in both cases). The input port is ready only while the sequencer is idle. A compute
// item passes through three setup states, then one tap per cycle through the single
// multiply-accumulate unit (each store has one read port, so one tap is read per cycle), a
// drain state that empties the read and multiply stages and a finish state that hands the
// result to the output register; an error status skips the tap walk and the drain. The
// output register frees the input side: further items are taken while an earlier result
// waits, and a finished sum waits in the last state only when the output register is still
// full. Configuration writes are always accepted and must only be issued while no compute
// item is in flight. Stores come out of reset undefined; reading an entry that was never
// written gives an undefined sum.
module direct_conv2d_engine #(
	parameter int unsigned MAX_CHANNELS = 16,
	parameter int unsigned MAX_DIM      = 32,
	parameter int unsigned MAX_KERNEL   = 5,
	parameter int unsigned DATA_WIDTH   = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// load_index[13:0], load_value[29:14], out_channel[33:30], out_row[39:34],
	// out_col[45:40], zero[47:46]
	input  wire logic [dconv_pkg::S_TDATA_W-1:0]   s_tdata,
	// kind[1:0]
	input  wire logic [dconv_pkg::S_TUSER_W-1:0]   s_tuser,
	// Result stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// conv_sum[39:0], res_channel[43:40], res_row[49:44], res_col[55:50]
	output logic [dconv_pkg::M_TDATA_W-1:0]        m_tdata,
	// status[1:0]
	output logic [dconv_pkg::M_TUSER_W-1:0]        m_tuser,
	// Configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [dconv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dconv_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// Store geometry follows from the limits.
	localparam int unsigned IN_DEPTH = MAX_CHANNELS * MAX_DIM * MAX_DIM;
	localparam int unsigned WT_DEPTH = MAX_CHANNELS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
	localparam int unsigned IA_W     = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
	localparam int unsigned WA_W     = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
	// A stored value keeps at most sixteen significant bits.
	localparam int unsigned SW       = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
	localparam int unsigned PROD_W   = 2 * SW;
	localparam int unsigned MAX_TAPS = MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
	localparam int unsigned ACC_RAW  = PROD_W + $clog2(MAX_TAPS + 1) + 1;
	localparam int unsigned ACC_W    = (ACC_RAW > dconv_pkg::SUM_W) ? ACC_RAW : dconv_pkg::SUM_W;
	// Coordinate and row offset widths (signed) for the tap walk.
	localparam int unsigned CW       = 12;
	localparam int unsigned RO_W     = 19;

	localparam logic signed [ACC_W-1:0] SAT_MAX =
		{{(ACC_W - dconv_pkg::SUM_W + 1){1'b0}}, {(dconv_pkg::SUM_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN =
		{{(ACC_W - dconv_pkg::SUM_W + 1){1'b1}}, {(dconv_pkg::SUM_W - 1){1'b0}}};

	// Input item fields
	dconv_pkg::kind_t                   kind;
	logic [dconv_pkg::LIDX_W-1:0]       load_index;
	logic [dconv_pkg::LVAL_W-1:0]       load_value;
	logic [dconv_pkg::OCH_W-1:0]        out_channel;
	logic [dconv_pkg::OPOS_W-1:0]       out_row;
	logic [dconv_pkg::OPOS_W-1:0]       out_col;
	logic                               s_xfer;

	// Configuration registers
	logic [4:0] in_channels_q;
	logic [5:0] in_height_q;
	logic [5:0] in_width_q;
	logic [4:0] out_channels_q;
	logic [2:0] kernel_height_q;
	logic [2:0] kernel_width_q;
	logic [3:0] step_size_q;
	logic [2:0] pad_amount_q;

	// Sequencer
	dconv_pkg::state_t state_q, state_d;
	logic               out_load;
	logic               last_tap;

	// Request and setup registers
	logic [dconv_pkg::OCH_W-1:0]  oc_q;
	logic [dconv_pkg::OPOS_W-1:0] orow_q;
	logic [dconv_pkg::OPOS_W-1:0] ocol_q;
	logic                         geo_ok_q;
	logic                         coord_ok_q;
	logic [9:0]                   row_scaled_q;
	logic [9:0]                   col_scaled_q;
	logic [11:0]                  hw_q;
	logic [5:0]                   kk_q;
	logic [10:0]                  ckk_q;
	logic signed [CW-1:0]         ystart_q;
	logic signed [CW-1:0]         xstart_q;
	logic signed [RO_W-1:0]       row_start_q;
	dconv_pkg::status_t           status_q;

	// Tap walk
	logic [4:0]             c_q;
	logic [2:0]             ky_q;
	logic [2:0]             kx_q;
	logic signed [CW-1:0]   iy_q;
	logic signed [CW-1:0]   ix_q;
	logic signed [RO_W-1:0] row_off_q;
	logic [IA_W-1:0]        chan_base_q;
	logic [WA_W-1:0]        wa_q;
	logic                   tap_ok;
	logic [IA_W-1:0]        ia;

	// Geometry helpers
	logic       geo_ok;
	logic [7:0] padded_h;
	logic [7:0] padded_w;

	// Stores and the MAC pipeline
	logic signed [SW-1:0]     in_mem [IN_DEPTH];
	logic signed [SW-1:0]     wt_mem [WT_DEPTH];
	logic signed [SW-1:0]     rd_in_s1;
	logic signed [SW-1:0]     rd_wt_s1;
	logic                     vld_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic [dconv_pkg::SUM_W-1:0] sum_sat;

	// Output register
	logic                             m_tvalid_q;
	logic [dconv_pkg::M_TDATA_W-1:0]  m_tdata_q;
	logic [dconv_pkg::M_TUSER_W-1:0]  m_tuser_q;

	// ------------------------------------------------------------------
	// Port unpacking
	// ------------------------------------------------------------------
	assign kind        = dconv_pkg::kind_t'(s_tuser[1:0]);
	assign load_index  = s_tdata[13:0];
	assign load_value  = s_tdata[29:14];
	assign out_channel = s_tdata[33:30];
	assign out_row     = s_tdata[39:34];
	assign out_col     = s_tdata[45:40];
	assign s_xfer      = s_tvalid & s_tready;

	// Configuration writes are taken at any time.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_channels_q   <= 5'd1;
			in_height_q     <= 6'd32;
			in_width_q      <= 6'd32;
			out_channels_q  <= 5'd1;
			kernel_height_q <= 3'd3;
			kernel_width_q  <= 3'd3;
			step_size_q     <= 4'd1;
			pad_amount_q    <= 3'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (dconv_pkg::cfg_reg_t'(cfg_index))
				dconv_pkg::REG_IN_CHANNELS:   in_channels_q   <= cfg_data[4:0];
				dconv_pkg::REG_IN_HEIGHT:     in_height_q     <= cfg_data[5:0];
				dconv_pkg::REG_IN_WIDTH:      in_width_q      <= cfg_data[5:0];
				dconv_pkg::REG_OUT_CHANNELS:  out_channels_q  <= cfg_data[4:0];
				dconv_pkg::REG_KERNEL_HEIGHT: kernel_height_q <= cfg_data[2:0];
				dconv_pkg::REG_KERNEL_WIDTH:  kernel_width_q  <= cfg_data[2:0];
				dconv_pkg::REG_STEP_SIZE:     step_size_q     <= cfg_data[3:0];
				dconv_pkg::REG_PAD_AMOUNT:    pad_amount_q    <= cfg_data[2:0];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Geometry check: every register within its range and the kernel no
	// larger than the padded input.
	// ------------------------------------------------------------------
	assign padded_h = 8'(in_height_q) + 8'({pad_amount_q, 1'b0});
	assign padded_w = 8'(in_width_q) + 8'({pad_amount_q, 1'b0});

	assign geo_ok = (in_channels_q != 5'd0) && (32'(in_channels_q) <= MAX_CHANNELS)
		&& (out_channels_q != 5'd0) && (32'(out_channels_q) <= MAX_CHANNELS)
		&& (in_height_q != 6'd0) && (32'(in_height_q) <= MAX_DIM)
		&& (in_width_q != 6'd0) && (32'(in_width_q) <= MAX_DIM)
		&& (kernel_height_q != 3'd0) && (32'(kernel_height_q) <= MAX_KERNEL)
		&& (kernel_width_q != 3'd0) && (32'(kernel_width_q) <= MAX_KERNEL)
		&& (step_size_q != 4'd0) && (32'(step_size_q) <= dconv_pkg::MAX_STEP)
		&& (32'(pad_amount_q) <= dconv_pkg::MAX_PAD)
		&& (8'(kernel_height_q) <= padded_h)
		&& (8'(kernel_width_q) <= padded_w);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	assign last_tap = (c_q == in_channels_q - 5'd1)
		&& (ky_q == kernel_height_q - 3'd1)
		&& (kx_q == kernel_width_q - 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dconv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			dconv_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && kind == dconv_pkg::KIND_COMPUTE) begin
					state_d = dconv_pkg::ST_SETUP0;
				end
			end
			dconv_pkg::ST_SETUP0: state_d = dconv_pkg::ST_SETUP1;
			dconv_pkg::ST_SETUP1: state_d = dconv_pkg::ST_SETUP2;
			dconv_pkg::ST_SETUP2: begin
				if (geo_ok_q && coord_ok_q) begin
					state_d = dconv_pkg::ST_RUN;
				end else begin
					state_d = dconv_pkg::ST_FINISH;
				end
			end
			dconv_pkg::ST_RUN: begin
				if (last_tap) begin
					state_d = dconv_pkg::ST_DRAIN;
				end
			end
			dconv_pkg::ST_DRAIN: begin
				// The last product has reached the accumulator once both stages are empty.
				if (!vld_s1 && !vld_s2) begin
					state_d = dconv_pkg::ST_FINISH;
				end
			end
			dconv_pkg::ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = dconv_pkg::ST_IDLE;
				end
			end
			default: state_d = dconv_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Setup: small products in SETUP0, SETUP1 and SETUP2 that prepare the tap walk.
	// The output-map bound is tested as row * step <= padded - kernel,
	// which avoids a division by the stride.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			dconv_pkg::ST_IDLE: begin
				if (s_xfer) begin
					oc_q   <= out_channel;
					orow_q <= out_row;
					ocol_q <= out_col;
				end
			end
			dconv_pkg::ST_SETUP0: begin
				geo_ok_q     <= geo_ok;
				row_scaled_q <= 10'(orow_q) * 10'(step_size_q);
				col_scaled_q <= 10'(ocol_q) * 10'(step_size_q);
				hw_q         <= 12'(in_height_q) * 12'(in_width_q);
				kk_q         <= 6'(kernel_height_q) * 6'(kernel_width_q);
			end
			dconv_pkg::ST_SETUP1: begin
				coord_ok_q <= (5'(oc_q) < out_channels_q)
					&& (row_scaled_q <= 10'(padded_h - 8'(kernel_height_q)))
					&& (col_scaled_q <= 10'(padded_w - 8'(kernel_width_q)));
				ystart_q   <= signed'(CW'(row_scaled_q) - CW'(pad_amount_q));
				xstart_q   <= signed'(CW'(col_scaled_q) - CW'(pad_amount_q));
				ckk_q      <= 11'(in_channels_q) * 11'(kk_q);
			end
			dconv_pkg::ST_SETUP2: begin
				row_start_q <= RO_W'(ystart_q) * signed'(RO_W'(in_width_q));
				if (!geo_ok_q) begin
					status_q <= dconv_pkg::STATUS_GEOMETRY;
				end else if (!coord_ok_q) begin
					status_q <= dconv_pkg::STATUS_RANGE;
				end else begin
					status_q <= dconv_pkg::STATUS_OK;
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Tap walk: channel, kernel row, kernel column, one tap per cycle.
	// Weight addresses are consecutive; the input address is rebuilt from
	// a channel base, a row offset and the column.
	// ------------------------------------------------------------------
	assign tap_ok = !iy_q[CW-1] && (iy_q < signed'(CW'(in_height_q)))
		&& !ix_q[CW-1] && (ix_q < signed'(CW'(in_width_q)));
	assign ia = chan_base_q + IA_W'(row_off_q) + IA_W'(ix_q);

	always_ff @(posedge clk) begin
		if (state_q == dconv_pkg::ST_SETUP2) begin
			c_q         <= 5'd0;
			ky_q        <= 3'd0;
			kx_q        <= 3'd0;
			iy_q        <= ystart_q;
			ix_q        <= xstart_q;
			row_off_q   <= RO_W'(ystart_q) * signed'(RO_W'(in_width_q));
			chan_base_q <= '0;
			wa_q        <= WA_W'(15'(oc_q) * 15'(ckk_q));
		end else if (state_q == dconv_pkg::ST_RUN) begin
			wa_q <= wa_q + WA_W'(1);
			if (kx_q == kernel_width_q - 3'd1) begin
				kx_q <= 3'd0;
				ix_q <= xstart_q;
				if (ky_q == kernel_height_q - 3'd1) begin
					ky_q        <= 3'd0;
					iy_q        <= ystart_q;
					row_off_q   <= row_start_q;
					c_q         <= c_q + 5'd1;
					chan_base_q <= chan_base_q + IA_W'(hw_q);
				end else begin
					ky_q      <= ky_q + 3'd1;
					iy_q      <= iy_q + CW'(1);
					row_off_q <= row_off_q + signed'(RO_W'(in_width_q));
				end
			end else begin
				kx_q <= kx_q + 3'd1;
				ix_q <= ix_q + CW'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stores: one write port for load items, one registered read port each.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s_xfer && kind == dconv_pkg::KIND_LOAD_INPUT && 32'(load_index) < IN_DEPTH) begin
			in_mem[IA_W'(load_index)] <= load_value[SW-1:0];
		end
		rd_in_s1 <= in_mem[ia];
	end

	always_ff @(posedge clk) begin
		if (s_xfer && kind == dconv_pkg::KIND_LOAD_WEIGHT && 32'(load_index) < WT_DEPTH) begin
			wt_mem[WA_W'(load_index)] <= load_value[SW-1:0];
		end
		rd_wt_s1 <= wt_mem[wa_q];
	end

	// ------------------------------------------------------------------
	// Shared multiply-accumulate: read, multiply, accumulate.
	// Taps that fall in the padding carry no valid flag and add nothing.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == dconv_pkg::ST_RUN) && tap_ok;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= rd_in_s1 * rd_wt_s1;
		if (state_q == dconv_pkg::ST_SETUP2) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	always_comb begin
		if (acc_q > SAT_MAX) begin
			sum_sat = SAT_MAX[dconv_pkg::SUM_W-1:0];
		end else if (acc_q < SAT_MIN) begin
			sum_sat = SAT_MIN[dconv_pkg::SUM_W-1:0];
		end else begin
			sum_sat = acc_q[dconv_pkg::SUM_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q[39:0]  <= (status_q == dconv_pkg::STATUS_OK) ? sum_sat : '0;
			m_tdata_q[43:40] <= oc_q;
			m_tdata_q[49:44] <= orow_q;
			m_tdata_q[55:50] <= ocol_q;
			m_tuser_q        <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// A product enters the pipeline only from a tap issued in the run state.
	a_vld_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q == dconv_pkg::ST_RUN))
		else $error("MAC pipeline loaded outside the tap walk");

	// The result is handed over only after the MAC pipeline has emptied.
	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dconv_pkg::ST_FINISH) |-> (!vld_s1 && !vld_s2))
		else $error("result taken while products were still in flight");

	// An error result always carries a zero sum.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != dconv_pkg::STATUS_OK) |-> (m_tdata[39:0] == '0))
		else $error("non-zero sum with an error status");

	// Every in-bounds tap reads inside the input store.
	a_ia_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dconv_pkg::ST_RUN && tap_ok) |-> (32'(ia) < IN_DEPTH))
		else $error("input store read out of range");

endmodule : direct_conv2d_engine

`default_nettype wire

// ----- tb/conv_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the direct 2D convolution engine: mirrors both stores and the registers,
// works out the sum for every compute transfer and compares it with the result stream.
// Depends on design/dconv_pkg.sv for item kinds, status codes, register indexes and widths.

module conv_result_checker
	import dconv_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	input  wire logic [S_TUSER_W-1:0]  s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [M_TDATA_W-1:0]  m_tdata,
	input  wire logic [M_TUSER_W-1:0]  m_tuser,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         awaiting
);

	localparam int SAMPLE_DEPTH = 16384;
	localparam int WEIGHT_DEPTH = 6400;
	localparam int CHAN_LIMIT   = 16;
	localparam int DIM_LIMIT    = 32;
	localparam int KERNEL_LIMIT = 5;
	localparam longint SUM_HIGH = 64'sd549755813887;
	localparam longint SUM_LOW  = -64'sd549755813888;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [OCH_W-1:0]        channel;
		logic [OPOS_W-1:0]       row;
		logic [OPOS_W-1:0]       col;
		status_t                 status;
	} conv_result_t;

	logic signed [LVAL_W-1:0] sample_mem [SAMPLE_DEPTH];
	logic signed [LVAL_W-1:0] weight_mem [WEIGHT_DEPTH];

	logic [4:0] n_in_ch, n_out_ch;
	logic [5:0] n_rows, n_cols;
	logic [2:0] k_rows, k_cols, pad;
	logic [3:0] step;

	conv_result_t awaited_results [$];

	// Sum of sample times weight over every input channel and kernel tap for one output
	// position, with stride and zero border; status codes take precedence over the sum.
	function automatic conv_result_t convolve_at(input logic [OCH_W-1:0] ch,
			input logic [OPOS_W-1:0] row, input logic [OPOS_W-1:0] col);
		conv_result_t r;
		int ic, oc, ih, iw, kh, kw, st, pd, h_out, w_out;
		int c, ky, kx, iy, ix, ia, wa;
		longint acc;
		r.sum = '0;
		r.channel = ch;
		r.row = row;
		r.col = col;
		r.status = STATUS_OK;
		ic = n_in_ch;
		oc = n_out_ch;
		ih = n_rows;
		iw = n_cols;
		kh = k_rows;
		kw = k_cols;
		st = step;
		pd = pad;
		acc = 0;
		if (ic < 1 || ic > CHAN_LIMIT || oc < 1 || oc > CHAN_LIMIT ||
				ih < 1 || ih > DIM_LIMIT || iw < 1 || iw > DIM_LIMIT ||
				kh < 1 || kh > KERNEL_LIMIT || kw < 1 || kw > KERNEL_LIMIT ||
				st < 1 || st > MAX_STEP || pd > MAX_PAD ||
				kh > ih + 2 * pd || kw > iw + 2 * pd) begin
			r.status = STATUS_GEOMETRY;
			return r;
		end
		h_out = (ih + 2 * pd - kh) / st + 1;
		w_out = (iw + 2 * pd - kw) / st + 1;
		if (ch >= oc || row >= h_out || col >= w_out) begin
			r.status = STATUS_RANGE;
			return r;
		end
		for (c = 0; c < ic; c++) begin
			for (ky = 0; ky < kh; ky++) begin
				for (kx = 0; kx < kw; kx++) begin
					iy = row * st + ky - pd;
					ix = col * st + kx - pd;
					// Taps on the zero border add nothing.
					if (iy < 0 || iy >= ih || ix < 0 || ix >= iw)
						continue;
					ia = c * ih * iw + iy * iw + ix;
					wa = ((ch * ic + c) * kh + ky) * kw + kx;
					if (ia >= SAMPLE_DEPTH || wa >= WEIGHT_DEPTH)
						continue;
					acc += longint'(sample_mem[ia]) * longint'(weight_mem[wa]);
				end
			end
		end
		if (acc > SUM_HIGH)
			acc = SUM_HIGH;
		if (acc < SUM_LOW)
			acc = SUM_LOW;
		r.sum = acc[SUM_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		conv_result_t got, want;
		if (!arst_n) begin
			n_in_ch = 5'd1;
			n_rows = 6'd32;
			n_cols = 6'd32;
			n_out_ch = 5'd1;
			k_rows = 3'd3;
			k_cols = 3'd3;
			step = 4'd1;
			pad = 3'd0;
			awaited_results.delete();
			awaiting = 0;
		end else begin
			// Results first: a result leaving in this cycle always belongs to an older request.
			if (m_tvalid && m_tready) begin
				got.sum = m_tdata[39:0];
				got.channel = m_tdata[43:40];
				got.row = m_tdata[49:44];
				got.col = m_tdata[55:50];
				got.status = status_t'(m_tuser);
				if (awaited_results.size() == 0) begin
					$error("result transfer with nothing outstanding: sum %0d status %0d",
						got.sum, got.status);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (got.sum !== want.sum) begin
						$error("conv_sum: expected %0d, actual %0d", want.sum, got.sum);
						fail_count++;
					end
					if (got.channel !== want.channel) begin
						$error("res_channel: expected %0d, actual %0d", want.channel,
							got.channel);
						fail_count++;
					end
					if (got.row !== want.row) begin
						$error("res_row: expected %0d, actual %0d", want.row, got.row);
						fail_count++;
					end
					if (got.col !== want.col) begin
						$error("res_col: expected %0d, actual %0d", want.col, got.col);
						fail_count++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_IN_CHANNELS:   n_in_ch = cfg_data[4:0];
					REG_IN_HEIGHT:     n_rows = cfg_data[5:0];
					REG_IN_WIDTH:      n_cols = cfg_data[5:0];
					REG_OUT_CHANNELS:  n_out_ch = cfg_data[4:0];
					REG_KERNEL_HEIGHT: k_rows = cfg_data[2:0];
					REG_KERNEL_WIDTH:  k_cols = cfg_data[2:0];
					REG_STEP_SIZE:     step = cfg_data[3:0];
					REG_PAD_AMOUNT:    pad = cfg_data[2:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					KIND_LOAD_INPUT: sample_mem[s_tdata[13:0]] = s_tdata[29:14];
					KIND_LOAD_WEIGHT: begin
						if (s_tdata[13:0] < WEIGHT_DEPTH)
							weight_mem[s_tdata[13:0]] = s_tdata[29:14];
					end
					KIND_COMPUTE: begin
						awaited_results.push_back(convolve_at(s_tdata[33:30], s_tdata[39:34],
							s_tdata[45:40]));
					end
					default: ;
				endcase
			end
			awaiting = awaited_results.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the convolution engine testbench: clock, reset, stimulus and the final verdict.
// Depends on design/dconv_pkg.sv, design/direct_conv2d_engine.sv and tb/conv_result_checker.sv.

module testbench;
	import dconv_pkg::*;

	// The one kind code the engine has no use for; such transfers are dropped.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int SAMPLE_DEPTH = 16384;
	localparam int WEIGHT_DEPTH = 6400;
	localparam int RANDOM_ITEMS = 1500;
	// Covers a compute item with every channel and tap in use.
	localparam int DRAIN_CYCLES = 450;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// load_index[13:0], load_value[29:14], out_channel[33:30], out_row[39:34],
	// out_col[45:40], zero[47:46]
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	// kind[1:0]
	logic [S_TUSER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// conv_sum[39:0], res_channel[43:40], res_row[49:44], res_col[55:50]
	logic [M_TDATA_W-1:0]  m_tdata;
	// status[1:0]
	logic [M_TUSER_W-1:0]  m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int awaiting;

	// When calm is set neither side idles, so some stretches run at full rate.
	bit calm = 1'b1;
	// Size of the output map under the current registers; zero when the setting is not sane.
	int map_chans = 1;
	int map_rows = 30;
	int map_cols = 30;
	int stall_left = 0;

	direct_conv2d_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	conv_result_checker result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.awaiting   (awaiting)
	);

	always #5 clk = ~clk;

	// Idle stretches: none in half the cases, else mostly short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Q8.8 value with the two extremes turning up often.
	function automatic logic [LVAL_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 16'h8000;
		if (r == 1)
			return 16'h7FFF;
		return $urandom;
	endfunction

	// The result side stalls at random; m_tready gets exactly one update per clock edge.
	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left = stall_left - 1;
		else if ($urandom_range(0, 3) == 0)
			stall_left = pick_gap();
		m_tready <= (stall_left == 0);
	end

	// One transfer on the input stream. tvalid is left high afterwards so that a following
	// item without a gap keeps it high; the caller lowers it when a run of items ends.
	task automatic push_item(input logic [KIND_W-1:0] kind, input logic [LIDX_W-1:0] idx,
			input logic [LVAL_W-1:0] value, input logic [OCH_W-1:0] ch,
			input logic [OPOS_W-1:0] row, input logic [OPOS_W-1:0] col);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {2'b00, col, row, ch, value, idx};
		// Ready is sampled at the falling edge before the clock edge so the outcome never hangs on
		// the order of events at the edge itself.
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
	endtask

	// Waits for every outstanding result, then for a trailing load to finish, so that the
	// registers can be rewritten with nothing in flight.
	task automatic settle();
		@(negedge clk);
		while (awaiting != 0) @(negedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Writes all eight registers; a sane setting also records the output map for stimulus.
	task automatic configure(input logic [7:0] ic, input logic [7:0] ih, input logic [7:0] iw,
			input logic [7:0] oc, input logic [7:0] kh, input logic [7:0] kw,
			input logic [7:0] st, input logic [7:0] pd, input bit sane);
		write_reg(REG_IN_CHANNELS, ic);
		write_reg(REG_IN_HEIGHT, ih);
		write_reg(REG_IN_WIDTH, iw);
		write_reg(REG_OUT_CHANNELS, oc);
		write_reg(REG_KERNEL_HEIGHT, kh);
		write_reg(REG_KERNEL_WIDTH, kw);
		write_reg(REG_STEP_SIZE, st);
		write_reg(REG_PAD_AMOUNT, pd);
		cfg_valid <= 1'b0;
		if (sane && ih + 2 * pd >= kh && iw + 2 * pd >= kw) begin
			map_chans = oc;
			map_rows = (ih + 2 * pd - kh) / st + 1;
			map_cols = (iw + 2 * pd - kw) / st + 1;
		end else begin
			map_chans = 0;
			map_rows = 0;
			map_cols = 0;
		end
	endtask

	// Compute request: mostly inside the output map, some just past its edge, some anywhere.
	task automatic push_compute();
		int unsigned r;
		logic [OCH_W-1:0] ch;
		logic [OPOS_W-1:0] row, col;
		r = $urandom_range(0, 9);
		ch = $urandom;
		row = $urandom;
		col = $urandom;
		if (map_rows != 0 && r < 8) begin
			ch = $urandom_range(0, map_chans - 1);
			row = $urandom_range(0, map_rows - 1);
			col = $urandom_range(0, map_cols - 1);
			if (r == 7) begin
				case ($urandom_range(0, 2))
					0: row = map_rows;
					1: col = map_cols;
					default: ch = map_chans;
				endcase
			end
		end
		push_item(KIND_COMPUTE, $urandom, $urandom, ch, row, col);
	endtask

	// One random item; counts is cleared for items that the engine simply drops.
	task automatic push_random(output bit counts);
		int unsigned r;
		r = $urandom_range(0, 99);
		counts = 1'b1;
		if (r < 55) begin
			push_compute();
		end else if (r < 75) begin
			push_item(KIND_LOAD_INPUT, $urandom, pick_value(), $urandom, $urandom, $urandom);
		end else if (r < 92) begin
			push_item(KIND_LOAD_WEIGHT, $urandom_range(0, WEIGHT_DEPTH - 1), pick_value(),
				$urandom, $urandom, $urandom);
		end else if (r < 97) begin
			push_item(KIND_LOAD_WEIGHT, $urandom_range(WEIGHT_DEPTH, SAMPLE_DEPTH - 1),
				pick_value(), $urandom, $urandom, $urandom);
			counts = 1'b0;
		end else begin
			push_item(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
			counts = 1'b0;
		end
	endtask

	initial begin
		int i, counted, phase_goal;
		bit counts;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every entry of both stores is written once up front, so no compute can ever
		// touch an entry that has never been written.
		for (i = 0; i < SAMPLE_DEPTH; i++)
			push_item(KIND_LOAD_INPUT, i, pick_value(), $urandom, $urandom, $urandom);
		for (i = 0; i < WEIGHT_DEPTH; i++)
			push_item(KIND_LOAD_WEIGHT, i, pick_value(), $urandom, $urandom, $urandom);
		calm = 1'b0;

		// Reset setting: a 3x3 kernel over a 32x32 map gives a 30x30 output.
		push_item(KIND_COMPUTE, 0, 0, 4'd0, 6'd0, 6'd0);
		push_item(KIND_COMPUTE, 0, 0, 4'd0, 6'd29, 6'd29);
		push_item(KIND_COMPUTE, 0, 0, 4'd0, 6'd30, 6'd0);
		push_item(KIND_COMPUTE, 0, 0, 4'd0, 6'd0, 6'd30);
		push_item(KIND_COMPUTE, 0, 0, 4'd1, 6'd0, 6'd0);
		push_item(KIND_COMPUTE, 0, 0, 4'd15, 6'd63, 6'd63);
		// Extreme values at the ends of both stores, loads past the weight store's end
		// and the unused kind.
		push_item(KIND_LOAD_INPUT, 14'd0, 16'h8000, 4'd0, 6'd0, 6'd0);
		push_item(KIND_LOAD_INPUT, 14'd16383, 16'h7FFF, 4'd15, 6'd63, 6'd63);
		push_item(KIND_LOAD_WEIGHT, 14'd0, 16'h7FFF, 4'd0, 6'd0, 6'd0);
		push_item(KIND_LOAD_WEIGHT, 14'd6399, 16'h8000, 4'd15, 6'd63, 6'd63);
		push_item(KIND_LOAD_WEIGHT, 14'd6400, 16'h1234, 4'd0, 6'd0, 6'd0);
		push_item(KIND_LOAD_WEIGHT, 14'd16383, 16'hFFFF, 4'd15, 6'd63, 6'd63);
		push_item(KIND_UNUSED, 14'h3FFF, 16'hFFFF, 4'hF, 6'h3F, 6'h3F);
		push_item(KIND_COMPUTE, 0, 0, 4'd0, 6'd0, 6'd0);
		s_tvalid <= 1'b0;

		// Largest setting: every channel, the biggest kernel, the widest stride and border.
		settle();
		configure(16, 32, 32, 16, 5, 5, 8, 4, 1'b1);
		push_item(KIND_COMPUTE, 0, 0, 4'd15, 6'd4, 6'd4);
		push_item(KIND_COMPUTE, 0, 0, 4'd0, 6'd0, 6'd0);
		push_item(KIND_COMPUTE, 0, 0, 4'd15, 6'd5, 6'd0);
		s_tvalid <= 1'b0;

		// Smallest setting: a single sample and a single weight.
		settle();
		configure(1, 1, 1, 1, 1, 1, 1, 0, 1'b1);
		push_item(KIND_COMPUTE, 0, 0, 4'd0, 6'd0, 6'd0);
		push_item(KIND_COMPUTE, 0, 0, 4'd0, 6'd1, 6'd0);
		s_tvalid <= 1'b0;

		// Kernel taller than the padded input.
		settle();
		configure(1, 1, 1, 1, 5, 1, 1, 1, 1'b1);
		push_item(KIND_COMPUTE, 0, 0, 4'd0, 6'd0, 6'd0);
		s_tvalid <= 1'b0;

		// Registers outside their ranges: no input channels, zero stride, oversized border.
		settle();
		configure(0, 32, 32, 1, 3, 3, 0, 5, 1'b0);
		push_item(KIND_COMPUTE, 0, 0, 4'd0, 6'd0, 6'd0);
		s_tvalid <= 1'b0;

		// Random phases, each under its own register setting.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			settle();
			case ($urandom_range(0, 9))
				0: configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, 1'b0);
				1: configure(16, 32, 32, 16, 5, 5, $urandom_range(1, 8),
					$urandom_range(0, 4), 1'b1);
				default: configure(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) :
					$urandom_range(1, 4), $urandom_range(1, 32), $urandom_range(1, 32),
					$urandom_range(1, 16), $urandom_range(1, 5), $urandom_range(1, 5),
					$urandom_range(1, 8), $urandom_range(0, 4), 1'b1);
			endcase
			calm = ($urandom_range(0, 4) == 0);
			phase_goal = counted + $urandom_range(40, 160);
			while (counted < phase_goal && counted < RANDOM_ITEMS) begin
				push_random(counts);
				counted += counts;
			end
			s_tvalid <= 1'b0;
		end

		@(negedge clk);
		while (awaiting != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// Hard limit on the whole run, far beyond the slowest correct one.
	initial begin
		#40_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
